/* hdl/assert_macros.svh */
// Assertion macros shared by the tracker modules.
// Each macro expects the including module to have ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/smmmt_pkg.sv */
// Package of the scaled min/max/mean tracker: widths, constants, state codes
// and the small constant tables used by the scaler and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package smmmt_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam int VALUE_WIDTH   = 18;
   localparam int PLACES_WIDTH  = 3;
   localparam int PREFIX_WIDTH  = 3;
   localparam int UNIT_WIDTH    = 8;
   localparam int SAMPLES_WIDTH = 32;
   localparam int FINE_WIDTH    = 64;

   localparam int REQ_DATA_WIDTH = 32;
   localparam int RSP_DATA_WIDTH = 104;

   // Scaling exponent is FINE_BASE - places + 3 * prefix, range -6 .. 22.
   localparam int FINE_BASE         = 13;
   localparam int PLACES_PER_PREFIX = 3;
   localparam int EXP_WIDTH         = 6;

   // Mean renormalization.
   localparam int TOP_PLACE     = 18;
   localparam int PLACE_WIDTH   = 5;
   localparam int NANO_PREFIX   = -3;
   localparam int PREFIX_OFFSET = 4;

   // Saturation limits of the scaler, as magnitudes.
   localparam logic [FINE_WIDTH-1:0] SAT_POS_MAG = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [FINE_WIDTH-1:0] SAT_NEG_MAG = 64'h8000_0000_0000_0000;
   localparam logic [FINE_WIDTH-1:0] MUL10_LIMIT = 64'd922337203685477580;

   // Exact divide by ten for values below 2^18: (n * 52429) >> 19.
   localparam logic [15:0] DIV10_RECIP = 16'd52429;
   localparam int          DIV10_SHIFT = 19;

   // Serial divider.
   localparam int DIV_WIDTH     = 64;
   localparam int ITER_WIDTH    = 7;
   localparam int AVG_QUOT_BITS = 17;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCALE,
      S_UPDATE,
      S_DIFF,
      S_DIV_MEAN,
      S_MAG,
      S_SEARCH,
      S_START_AVG,
      S_DIV_AVG,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic signed [PREFIX_WIDTH-1:0] prefix;
      logic [PLACE_WIDTH-1:0]         divisor_place;
   } avg_scale_type;

   function automatic logic [FINE_WIDTH-1:0] pow10(input logic [PLACE_WIDTH-1:0] place);
      logic [FINE_WIDTH-1:0] result;
      unique case (place)
         5'd0:  result = 64'd1;
         5'd1:  result = 64'd10;
         5'd2:  result = 64'd100;
         5'd3:  result = 64'd1000;
         5'd4:  result = 64'd10000;
         5'd5:  result = 64'd100000;
         5'd6:  result = 64'd1000000;
         5'd7:  result = 64'd10000000;
         5'd8:  result = 64'd100000000;
         5'd9:  result = 64'd1000000000;
         5'd10: result = 64'd10000000000;
         5'd11: result = 64'd100000000000;
         5'd12: result = 64'd1000000000000;
         5'd13: result = 64'd10000000000000;
         5'd14: result = 64'd100000000000000;
         5'd15: result = 64'd1000000000000000;
         5'd16: result = 64'd10000000000000000;
         5'd17: result = 64'd100000000000000000;
         5'd18: result = 64'd1000000000000000000;
         default: result = '0;
      endcase
      return result;
   endfunction

   // Engineering prefix and divisor exponent of the mean, from the highest
   // nonzero decimal place. A zero mean behaves like place zero.
   function automatic avg_scale_type avg_scale_of(input logic [PLACE_WIDTH-1:0] place);
      int            group;
      int            prefix;
      avg_scale_type result;
      priority if (int'(place) < 3) begin
         group = 0;
      end else if (int'(place) < 6) begin
         group = 1;
      end else if (int'(place) < 9) begin
         group = 2;
      end else if (int'(place) < 12) begin
         group = 3;
      end else if (int'(place) < 15) begin
         group = 4;
      end else if (int'(place) < 18) begin
         group = 5;
      end else begin
         group = 6;
      end
      if (group <= 1) begin
         prefix = NANO_PREFIX;
      end else begin
         prefix = group - PREFIX_OFFSET;
      end
      result.prefix        = PREFIX_WIDTH'(prefix);
      result.divisor_place = PLACE_WIDTH'(FINE_BASE - PLACES_PER_PREFIX
                                          + PLACES_PER_PREFIX * prefix);
      return result;
   endfunction

endpackage

`default_nettype wire

/* hdl/smmmt_scaler.sv */
// Decade-serial scaler: converts one reading to the common fine unit, one
// power of ten per cycle, with saturation to signed 64 bits.
// Depends on smmmt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module smmmt_scaler (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic signed [smmmt_pkg::VALUE_WIDTH-1:0]    sample_value,
   input  logic        [smmmt_pkg::PLACES_WIDTH-1:0]   decimal_places,
   input  logic signed [smmmt_pkg::PREFIX_WIDTH-1:0]   prefix_exp,
   output logic                                        done,
   output logic signed [smmmt_pkg::FINE_WIDTH-1:0]     scaled
);

   localparam int VW = smmmt_pkg::VALUE_WIDTH;
   localparam int FW = smmmt_pkg::FINE_WIDTH;
   localparam int EW = smmmt_pkg::EXP_WIDTH;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [FW-1:0]        mag_ff, mag_in;
   logic signed [EW-1:0] exp_ff, exp_in;
   logic signed [FW-1:0] scaled_ff, scaled_in;

   logic [VW:0]          abs_value;
   logic signed [EW-1:0] exp_start;
   logic [VW+15:0]       div10_product;

   assign abs_value = sample_value[VW-1] ? ('0 - {1'b1, sample_value})
                                         : {1'b0, sample_value};

   assign exp_start = EW'(smmmt_pkg::FINE_BASE) - EW'(decimal_places)
                      + EW'(smmmt_pkg::PLACES_PER_PREFIX * int'(prefix_exp));

   // The value is below 2^18 whenever it is being divided.
   assign div10_product = (VW+16)'(mag_ff[VW-1:0]) * (VW+16)'(smmmt_pkg::DIV10_RECIP);

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      exp_in    = exp_ff;
      scaled_in = scaled_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = sample_value[VW-1];
         mag_in  = FW'(abs_value);
         exp_in  = exp_start;
      end else if (busy_ff) begin
         if (exp_ff == '0) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            scaled_in = neg_ff ? ('0 - mag_ff) : mag_ff;
         end else if (!exp_ff[EW-1]) begin
            if (mag_ff > smmmt_pkg::MUL10_LIMIT) begin
               mag_in = neg_ff ? smmmt_pkg::SAT_NEG_MAG : smmmt_pkg::SAT_POS_MAG;
               exp_in = '0;
            end else begin
               mag_in = (mag_ff << 3) + (mag_ff << 1);
               exp_in = exp_ff - EW'(1);
            end
         end else begin
            mag_in = FW'(div10_product[VW+15:smmmt_pkg::DIV10_SHIFT]);
            exp_in = exp_ff + EW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      exp_ff    <= exp_in;
      scaled_ff <= scaled_in;
   end

   assign done   = done_ff;
   assign scaled = scaled_ff;

   `ASSERT_IMPLIES(a_divide_stays_narrow, busy_ff && exp_ff[EW-1], mag_ff[FW-1:VW] == '0, "scaler divides a value wider than a reading")

endmodule

`default_nettype wire

/* hdl/smmmt_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle, with a
// programmable number of steps and a preloaded partial remainder.
// Depends on smmmt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module smmmt_divider (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [smmmt_pkg::DIV_WIDTH-1:0]        dividend,
   input  logic [smmmt_pkg::DIV_WIDTH-1:0]        rem_init,
   input  logic [smmmt_pkg::DIV_WIDTH-1:0]        divisor,
   input  logic [smmmt_pkg::ITER_WIDTH-1:0]       iterations,
   output logic                                   done,
   output logic [smmmt_pkg::DIV_WIDTH-1:0]        quotient
);

   localparam int W  = smmmt_pkg::DIV_WIDTH;
   localparam int IW = smmmt_pkg::ITER_WIDTH;

   logic          busy_ff;
   logic          done_ff;
   logic [IW-1:0] cnt_ff;
   logic [W-1:0]  rem_ff;
   logic [W-1:0]  dvd_ff;
   logic [W-1:0]  quo_ff;
   logic [W-1:0]  divisor_ff;

   logic [W:0]    trial;
   logic [W:0]    trial_diff;
   logic          fits;

   // Bring down the next dividend bit and try to subtract the divisor.
   assign trial      = {rem_ff, dvd_ff[W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign fits       = trial >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // Done pulses for one cycle after the last quotient bit is formed.
         done_ff <= !start && busy_ff && (cnt_ff == IW'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= iterations;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - IW'(1);
            if (cnt_ff == IW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= rem_init;
         dvd_ff     <= dividend;
         quo_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial_diff[W-1:0] : trial[W-1:0];
         dvd_ff <= dvd_ff << 1;
         quo_ff <= {quo_ff[W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `ASSERT_IMPLIES(a_remainder_below_divisor, busy_ff, rem_ff < divisor_ff, "divider partial remainder reached the divisor")

endmodule

`default_nettype wire

/* hdl/scaled_min_max_mean_tracker_core.sv */
// Top level of the scaled min/max/mean tracker: control sequencer, statistics
// registers and the result register. Uses smmmt_scaler and smmmt_divider,
// and depends on smmmt_pkg and assert_macros.svh.
//
//   Port group  Dir  Payload (lowest bits first)                      Handshake
//   req_        in   tdata: reading fields; tuser: clear_stats         tvalid/tready
//   rsp_        out  tdata: min, max, mean, prefix, count              tvalid/tready
//
// From acceptance to its result an item passes the decade scaler, the
// statistics update, the bit-serial mean divide, the decimal place search
// of the mean and the normalizing divide, in that order; the mean divide
// takes the largest share. Reset is synchronous; it empties the result
// register and arms a restart so the first item starts fresh statistics.
// A stalled result holds in its register while the next item is already
// accepted and worked on.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module scaled_min_max_mean_tracker_core #(
   parameter int COUNT_WIDTH = smmmt_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,

   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // sample_value[17:0], decimal_places[20:18], prefix_exp[23:21], unit_code[31:24]
   input  logic [smmmt_pkg::REQ_DATA_WIDTH-1:0]        req_tdata,
   // clear_stats
   input  logic                                        req_tuser,

   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // min_value[17:0], min_decimal[20:18], min_prefix[23:21], max_value[41:24],
   // max_decimal[44:42], max_prefix[47:45], avg_value[65:48], avg_prefix[68:66],
   // samples_seen[100:69], zero fill[103:101]
   output logic [smmmt_pkg::RSP_DATA_WIDTH-1:0]        rsp_tdata
);

   localparam int VW  = smmmt_pkg::VALUE_WIDTH;
   localparam int DW  = smmmt_pkg::PLACES_WIDTH;
   localparam int PW  = smmmt_pkg::PREFIX_WIDTH;
   localparam int UW  = smmmt_pkg::UNIT_WIDTH;
   localparam int SW  = smmmt_pkg::SAMPLES_WIDTH;
   localparam int FW  = smmmt_pkg::FINE_WIDTH;
   localparam int LW  = smmmt_pkg::PLACE_WIDTH;
   localparam int IW  = smmmt_pkg::ITER_WIDTH;
   localparam int QB  = smmmt_pkg::AVG_QUOT_BITS;

   // Request field offsets.
   localparam int PLACES_LSB = VW;
   localparam int PREFIX_LSB = PLACES_LSB + DW;
   localparam int UNIT_LSB   = PREFIX_LSB + PW;

   // Offset of samples_seen in the result word.
   localparam int SAMPLES_LSB = 3 * (VW + PW) + 2 * DW + VW - VW + 0;

   smmmt_pkg::state_type state_ff, state_in;

   // Captured reading.
   logic signed [VW-1:0] in_value_ff;
   logic [DW-1:0]        in_places_ff;
   logic signed [PW-1:0] in_prefix_ff;
   logic [UW-1:0]        in_unit_ff;
   logic                 in_clear_ff;

   // Statistics.
   logic                   restart_pending_ff;
   logic [UW-1:0]          last_unit_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic signed [VW-1:0]   min_value_ff, max_value_ff;
   logic [DW-1:0]          min_places_ff, max_places_ff;
   logic signed [PW-1:0]   min_prefix_ff, max_prefix_ff;
   logic signed [FW-1:0]   min_fine_ff, max_fine_ff;
   logic signed [FW-1:0]   mean_ff;

   // Mean update and renormalization.
   logic                   ge_ff;
   logic [FW-1:0]          mag_ff;
   logic                   neg_ff;
   logic [LW-1:0]          place_ff;
   logic signed [PW-1:0]   avg_prefix_ff;
   logic [FW-1:0]          avg_divisor_ff;
   logic signed [VW-1:0]   avg_value_ff;

   // Result register.
   logic                   rsp_tvalid_ff;
   logic [smmmt_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata_ff;

   // Unit interfaces.
   logic                 scale_start;
   logic                 scale_done;
   logic signed [FW-1:0] scaled;
   logic                 div_start;
   logic [FW-1:0]        div_dividend;
   logic [FW-1:0]        div_rem_init;
   logic [FW-1:0]        div_divisor;
   logic [IW-1:0]        div_iterations;
   logic                 div_done;
   logic [FW-1:0]        div_quotient;

   // Combinational helpers.
   logic                    restart;
   logic [COUNT_WIDTH-1:0]  count_next;
   logic                    ge_now;
   logic [FW-1:0]           diff_pos, diff_neg;
   logic                    place_hit;
   smmmt_pkg::avg_scale_type avg_scale;
   logic [FW-1:0]           count_wide;
   logic [SW-1:0]           samples_seen;
   logic [VW-1:0]           avg_quot;
   logic                    rsp_free;

   smmmt_scaler u_scaler (
      .clock          (clock),
      .reset          (reset),
      .start          (scale_start),
      .sample_value   (req_tdata[VW-1:0]),
      .decimal_places (req_tdata[PREFIX_LSB-1:PLACES_LSB]),
      .prefix_exp     (req_tdata[UNIT_LSB-1:PREFIX_LSB]),
      .done           (scale_done),
      .scaled         (scaled)
   );

   smmmt_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend   (div_dividend),
      .rem_init   (div_rem_init),
      .divisor    (div_divisor),
      .iterations (div_iterations),
      .done       (div_done),
      .quotient   (div_quotient)
   );

   // A restart comes on request, on a change of unit, or on the first item.
   assign restart = restart_pending_ff || in_clear_ff || (in_unit_ff != last_unit_ff);

   assign count_next = restart    ? COUNT_WIDTH'(1) :
                       &count_ff  ? count_ff        : count_ff + COUNT_WIDTH'(1);

   // Both differences are formed in parallel; the sign picks one.
   assign ge_now   = scaled >= mean_ff;
   assign diff_pos = scaled - mean_ff;
   assign diff_neg = mean_ff - scaled;

   // The search stops at the highest power of ten not above the mean's
   // magnitude; a zero mean ends at place zero, which scales the same way.
   assign place_hit = (mag_ff >= smmmt_pkg::pow10(place_ff)) || (place_ff == '0);
   assign avg_scale = smmmt_pkg::avg_scale_of(place_ff);

   // The mean update divides the full difference by the count. The
   // normalizing divide is known to give fewer than 2^17, so the divider
   // starts with the upper bits already in the remainder.
   always_comb begin
      if (state_ff == smmmt_pkg::S_DIFF) begin
         div_dividend   = ge_now ? diff_pos : diff_neg;
         div_rem_init   = '0;
         div_divisor    = FW'(count_ff);
         div_iterations = IW'(smmmt_pkg::DIV_WIDTH);
      end else begin
         div_dividend   = mag_ff << (smmmt_pkg::DIV_WIDTH - QB);
         div_rem_init   = mag_ff >> QB;
         div_divisor    = avg_divisor_ff;
         div_iterations = IW'(QB);
      end
   end

   assign count_wide   = FW'(count_ff);
   assign samples_seen = (|count_wide[FW-1:SW]) ? '1 : count_wide[SW-1:0];
   assign avg_quot     = div_quotient[VW-1:0];
   assign rsp_free     = !rsp_tvalid_ff || rsp_tready;
   assign scale_start  = req_tvalid && req_tready;

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         smmmt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = smmmt_pkg::S_SCALE;
            end
         end
         smmmt_pkg::S_SCALE: begin
            if (scale_done) begin
               state_in = smmmt_pkg::S_UPDATE;
            end
         end
         smmmt_pkg::S_UPDATE: begin
            state_in = smmmt_pkg::S_DIFF;
         end
         smmmt_pkg::S_DIFF: begin
            div_start = 1'b1;
            state_in  = smmmt_pkg::S_DIV_MEAN;
         end
         smmmt_pkg::S_DIV_MEAN: begin
            if (div_done) begin
               state_in = smmmt_pkg::S_MAG;
            end
         end
         smmmt_pkg::S_MAG: begin
            state_in = smmmt_pkg::S_SEARCH;
         end
         smmmt_pkg::S_SEARCH: begin
            if (place_hit) begin
               state_in = smmmt_pkg::S_START_AVG;
            end
         end
         smmmt_pkg::S_START_AVG: begin
            div_start = 1'b1;
            state_in  = smmmt_pkg::S_DIV_AVG;
         end
         smmmt_pkg::S_DIV_AVG: begin
            if (div_done) begin
               state_in = smmmt_pkg::S_FINISH;
            end
         end
         smmmt_pkg::S_FINISH: begin
            if (rsp_free) begin
               state_in = smmmt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = smmmt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smmmt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control state that must come out of reset known.
   always_ff @(posedge clock) begin
      if (reset) begin
         restart_pending_ff <= 1'b1;
         last_unit_ff       <= '0;
         count_ff           <= '0;
         rsp_tvalid_ff      <= 1'b0;
      end else begin
         if (state_ff == smmmt_pkg::S_UPDATE) begin
            restart_pending_ff <= 1'b0;
            last_unit_ff       <= in_unit_ff;
            count_ff           <= count_next;
         end
         if (state_ff == smmmt_pkg::S_FINISH && rsp_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (scale_start) begin
         in_value_ff  <= req_tdata[VW-1:0];
         in_places_ff <= req_tdata[PREFIX_LSB-1:PLACES_LSB];
         in_prefix_ff <= req_tdata[UNIT_LSB-1:PREFIX_LSB];
         in_unit_ff   <= req_tdata[UNIT_LSB+UW-1:UNIT_LSB];
         in_clear_ff  <= req_tuser;
      end

      if (state_ff == smmmt_pkg::S_UPDATE) begin
         // Ties keep the stored reading.
         if (restart || (max_fine_ff < scaled)) begin
            max_value_ff  <= in_value_ff;
            max_places_ff <= in_places_ff;
            max_prefix_ff <= in_prefix_ff;
            max_fine_ff   <= scaled;
         end
         if (restart || (scaled < min_fine_ff)) begin
            min_value_ff  <= in_value_ff;
            min_places_ff <= in_places_ff;
            min_prefix_ff <= in_prefix_ff;
            min_fine_ff   <= scaled;
         end
         if (restart) begin
            mean_ff <= '0;
         end
      end

      if (state_ff == smmmt_pkg::S_DIFF) begin
         ge_ff <= ge_now;
      end

      // Running mean: mean moves toward the new value by |x - mean| / n.
      if (state_ff == smmmt_pkg::S_DIV_MEAN && div_done) begin
         mean_ff <= ge_ff ? (mean_ff + div_quotient) : (mean_ff - div_quotient);
      end

      if (state_ff == smmmt_pkg::S_MAG) begin
         neg_ff   <= mean_ff[FW-1];
         mag_ff   <= mean_ff[FW-1] ? ('0 - mean_ff) : mean_ff;
         place_ff <= LW'(smmmt_pkg::TOP_PLACE);
      end

      if (state_ff == smmmt_pkg::S_SEARCH) begin
         if (place_hit) begin
            avg_prefix_ff  <= avg_scale.prefix;
            avg_divisor_ff <= smmmt_pkg::pow10(avg_scale.divisor_place);
         end else begin
            place_ff <= place_ff - LW'(1);
         end
      end

      if (state_ff == smmmt_pkg::S_DIV_AVG && div_done) begin
         avg_value_ff <= neg_ff ? ('0 - avg_quot) : avg_quot;
      end

      if (state_ff == smmmt_pkg::S_FINISH && rsp_free) begin
         rsp_tdata_ff <= smmmt_pkg::RSP_DATA_WIDTH'({samples_seen,
                                                     avg_prefix_ff, avg_value_ff,
                                                     max_prefix_ff, max_places_ff,
                                                     max_value_ff,
                                                     min_prefix_ff, min_places_ff,
                                                     min_value_ff});
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `ASSERT_IMPLIES(a_result_counts_item, rsp_tvalid_ff, rsp_tdata_ff[SAMPLES_LSB+SW-1:SAMPLES_LSB] != '0, "result shows a zero sample count")
   `ASSERT_NEXT(a_pending_result_kept, (state_ff == smmmt_pkg::S_FINISH) && rsp_tvalid_ff && !rsp_tready, state_ff == smmmt_pkg::S_FINISH, "finished item overran a waiting result")
   `ASSERT_IMPLIES(a_min_not_above_max, !restart_pending_ff, min_fine_ff <= max_fine_ff, "tracked minimum lies above tracked maximum")

endmodule

`default_nettype wire

/* tb/scaled_min_max_mean_tracker_core_tb.sv */
// Testbench of scaled_min_max_mean_tracker_core: streams meter readings and
// checks every summary item against a scoreboard model kept in this file.
// Depends on smmmt_pkg and on the RTL of the tracker.
`timescale 1ns / 1ps

module scaled_min_max_mean_tracker_core_tb;

   localparam int VALUE_WIDTH       = smmmt_pkg::VALUE_WIDTH;
   localparam int PLACES_WIDTH      = smmmt_pkg::PLACES_WIDTH;
   localparam int PREFIX_WIDTH      = smmmt_pkg::PREFIX_WIDTH;
   localparam int UNIT_WIDTH        = smmmt_pkg::UNIT_WIDTH;
   localparam int SAMPLES_WIDTH     = smmmt_pkg::SAMPLES_WIDTH;
   localparam int REQ_DATA_WIDTH    = smmmt_pkg::REQ_DATA_WIDTH;
   localparam int RSP_DATA_WIDTH    = smmmt_pkg::RSP_DATA_WIDTH;
   localparam int FINE_BASE         = smmmt_pkg::FINE_BASE;
   localparam int PLACES_PER_PREFIX = smmmt_pkg::PLACES_PER_PREFIX;
   localparam int TOP_PLACE         = smmmt_pkg::TOP_PLACE;
   localparam int NANO_PREFIX       = smmmt_pkg::NANO_PREFIX;
   localparam int PREFIX_OFFSET     = smmmt_pkg::PREFIX_OFFSET;

   localparam int CLOCK_PERIOD        = 8;
   localparam int STALL_LIMIT         = 4000;
   localparam int DRAIN_CYCLES        = 160;
   localparam int RANDOM_ITEMS        = 680;
   localparam int TRACKED_COUNT_WIDTH = smmmt_pkg::COUNT_WIDTH_DEFAULT;

   typedef struct {
      logic [VALUE_WIDTH-1:0]   min_value;
      logic [PLACES_WIDTH-1:0]  min_decimal;
      logic [PREFIX_WIDTH-1:0]  min_prefix;
      logic [VALUE_WIDTH-1:0]   max_value;
      logic [PLACES_WIDTH-1:0]  max_decimal;
      logic [PREFIX_WIDTH-1:0]  max_prefix;
      logic [VALUE_WIDTH-1:0]   avg_value;
      logic [PREFIX_WIDTH-1:0]  avg_prefix;
      logic [SAMPLES_WIDTH-1:0] samples_seen;
   } summary_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic                      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   // Tracker state as the scoreboard sees it.
   logic [VALUE_WIDTH-1:0]   least_counts, most_counts;
   logic [PLACES_WIDTH-1:0]  least_places, most_places;
   logic [PREFIX_WIDTH-1:0]  least_prefix, most_prefix;
   logic signed [63:0]       running_mean;
   logic [63:0]              reading_count;
   logic [UNIT_WIDTH-1:0]    prev_unit;
   bit                       fresh_start;

   summary_type pending_summaries[$];
   int          fault_count;
   int          items_sent;
   bit          allow_gaps;

   scaled_min_max_mean_tracker_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Scales a reading to the common fine unit: counts * 10^(13 - places + 3 * prefix),
   // saturating to signed 64 bits and truncating toward zero for negative exponents.
   function automatic logic signed [63:0] to_fine_units(input logic [VALUE_WIDTH-1:0] counts,
                                                       input logic [PLACES_WIDTH-1:0] places,
                                                       input logic [PREFIX_WIDTH-1:0] prefix);
      logic signed [63:0] counts_wide;
      logic [63:0]        mag;
      logic [63:0]        ceiling;
      bit                 neg;
      bit                 clipped;
      int                 expo;
      int                 i;
      counts_wide = 64'($signed(counts));
      neg         = counts[VALUE_WIDTH-1];
      mag         = neg ? -counts_wide : counts_wide;
      expo        = FINE_BASE - int'(places) + PLACES_PER_PREFIX * int'($signed(prefix));
      ceiling     = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      clipped     = 1'b0;
      for (i = 0; i < expo; i++) begin
         if (!clipped) begin
            if (mag > ceiling / 64'd10) begin
               mag     = ceiling;
               clipped = 1'b1;
            end else begin
               mag = mag * 64'd10;
            end
         end
      end
      for (i = 0; i < -expo; i++) begin
         mag = mag / 64'd10;
      end
      return neg ? $signed(-mag) : $signed(mag);
   endfunction

   // Advances the scoreboard state by one reading and queues the summary it produces.
   task automatic predict_summary(input logic [VALUE_WIDTH-1:0] counts,
                                  input logic [PLACES_WIDTH-1:0] places,
                                  input logic [PREFIX_WIDTH-1:0] prefix,
                                  input logic [UNIT_WIDTH-1:0] unit,
                                  input bit clear_flag);
      logic signed [63:0] fine;
      logic [63:0]        diff;
      logic [63:0]        mean_mag;
      logic [63:0]        power;
      logic [63:0]        divisor;
      logic [63:0]        scaled_mag;
      logic [63:0]        count_ceiling;
      bit                 restart;
      int                 top_place;
      int                 eng_prefix;
      int                 k;
      summary_type        summary;
      count_ceiling = {64{1'b1}} >> (64 - TRACKED_COUNT_WIDTH);
      fine          = to_fine_units(counts, places, prefix);
      restart       = fresh_start || clear_flag || (unit != prev_unit);
      prev_unit     = unit;
      if (restart) begin
         running_mean  = '0;
         reading_count = '0;
      end
      if (reading_count < count_ceiling) begin
         reading_count = reading_count + 64'd1;
      end
      // Ties keep the stored reading, so only a strictly larger or smaller value replaces it.
      if (restart || to_fine_units(most_counts, most_places, most_prefix) < fine) begin
         most_counts = counts;
         most_places = places;
         most_prefix = prefix;
      end
      if (restart || fine < to_fine_units(least_counts, least_places, least_prefix)) begin
         least_counts = counts;
         least_places = places;
         least_prefix = prefix;
      end
      fresh_start = 1'b0;

      // Running mean with the difference taken as an unsigned magnitude.
      if (fine >= running_mean) begin
         diff         = fine - running_mean;
         running_mean = running_mean + diff / reading_count;
      end else begin
         diff         = running_mean - fine;
         running_mean = running_mean - diff / reading_count;
      end

      // Engineering prefix from the highest nonzero decimal place of the mean.
      mean_mag  = running_mean[63] ? -running_mean : running_mean;
      top_place = -1;
      power     = 64'd1;
      for (k = 0; k <= TOP_PLACE; k++) begin
         if (mean_mag >= power) begin
            top_place = k;
         end
         if (k < TOP_PLACE) begin
            power = power * 64'd10;
         end
      end
      if (top_place / PLACES_PER_PREFIX == 0) begin
         eng_prefix = NANO_PREFIX;
      end else begin
         eng_prefix = top_place / PLACES_PER_PREFIX - PREFIX_OFFSET;
      end
      divisor = 64'd1;
      for (k = 0; k < FINE_BASE - PLACES_PER_PREFIX + PLACES_PER_PREFIX * eng_prefix; k++) begin
         divisor = divisor * 64'd10;
      end
      scaled_mag = mean_mag / divisor;
      if (running_mean[63]) begin
         scaled_mag = -scaled_mag;
      end

      summary.min_value    = least_counts;
      summary.min_decimal  = least_places;
      summary.min_prefix   = least_prefix;
      summary.max_value    = most_counts;
      summary.max_decimal  = most_places;
      summary.max_prefix   = most_prefix;
      summary.avg_value    = scaled_mag[VALUE_WIDTH-1:0];
      summary.avg_prefix   = PREFIX_WIDTH'(eng_prefix);
      summary.samples_seen = (reading_count > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                              : reading_count[31:0];
      pending_summaries.push_back(summary);
   endtask

   // Sends one reading; called right after a falling edge and returns after one.
   task automatic send_reading(input logic [VALUE_WIDTH-1:0] counts,
                               input logic [PLACES_WIDTH-1:0] places,
                               input logic [PREFIX_WIDTH-1:0] prefix,
                               input logic [UNIT_WIDTH-1:0] unit,
                               input bit clear_flag);
      while (allow_gaps && $urandom_range(0, 99) < 10) begin
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {unit, prefix, places, counts};
      req_tuser  = clear_flag;
      do begin
         @(posedge clock);
      end while (!req_tready);
      predict_summary(counts, places, prefix, unit, clear_flag);
      items_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, expected, actual);
         fault_count++;
      end
   endtask

   // Each accepted summary item is matched against the oldest prediction.
   always @(posedge clock) begin
      summary_type golden;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_summaries.size() == 0) begin
            $display("%0t ns: unexpected summary item, expected none, actual 0x%0h",
                     $time, rsp_tdata);
            fault_count++;
         end else begin
            golden = pending_summaries.pop_front();
            check_field("min_value",    32'(golden.min_value),    32'(rsp_tdata[17:0]));
            check_field("min_decimal",  32'(golden.min_decimal),  32'(rsp_tdata[20:18]));
            check_field("min_prefix",   32'(golden.min_prefix),   32'(rsp_tdata[23:21]));
            check_field("max_value",    32'(golden.max_value),    32'(rsp_tdata[41:24]));
            check_field("max_decimal",  32'(golden.max_decimal),  32'(rsp_tdata[44:42]));
            check_field("max_prefix",   32'(golden.max_prefix),   32'(rsp_tdata[47:45]));
            check_field("avg_value",    32'(golden.avg_value),    32'(rsp_tdata[65:48]));
            check_field("avg_prefix",   32'(golden.avg_prefix),   32'(rsp_tdata[68:66]));
            check_field("samples_seen", golden.samples_seen, rsp_tdata[100:69]);
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready = !(allow_gaps && $urandom_range(0, 99) < 10);
   end

   // Watchdog: ends the run when no item moves on either side for too long.
   initial begin
      int stuck_cycles;
      stuck_cycles = 0;
      while (stuck_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
         end
      end
      $display("Test completed with failures");
      $finish;
   end

   // The first reading after reset restarts even on unit code zero.
   task automatic test_restart_after_reset();
      send_reading(18'sd1234, 3'd3, 3'sd0, 8'd0, 1'b0);
      send_reading(18'sd0, 3'd0, 3'sd0, 8'd0, 1'b0);
   endtask

   // Largest exponent overflows 64 bits; equal saturated values tie and keep the stored reading.
   task automatic test_saturation_and_ties();
      send_reading(18'sd99999, 3'd0, 3'sd3, 8'd0, 1'b0);
      send_reading(-18'sd99999, 3'd0, 3'sd3, 8'd0, 1'b0);
      send_reading(18'h1FFFF, 3'd0, 3'sd3, 8'd0, 1'b0);
      send_reading(18'h20000, 3'd0, 3'sd3, 8'd0, 1'b0);
      send_reading(18'sd7, 3'd2, -3'sd1, 8'd0, 1'b1);
      send_reading(18'sd70, 3'd3, -3'sd1, 8'd0, 1'b0);
   endtask

   // Negative exponents divide and truncate toward zero; the prefix pattern 3'b100 included.
   task automatic test_truncation_toward_zero();
      send_reading(-18'sd99999, 3'd7, 3'b100, 8'd0, 1'b0);
      send_reading(18'sd5, 3'd7, -3'sd3, 8'd0, 1'b0);
      send_reading(-18'sd1, 3'd7, -3'sd3, 8'd170, 1'b1);
      send_reading(18'sd99999, 3'd7, 3'b100, 8'd170, 1'b0);
   endtask

   task automatic test_clear_and_unit_change();
      send_reading(18'sd42, 3'd1, 3'sd1, 8'd255, 1'b0);
      send_reading(18'sd42, 3'd1, 3'sd1, 8'd255, 1'b0);
      send_reading(-18'sd500, 3'd1, 3'sd1, 8'd255, 1'b0);
      send_reading(18'sd9, 3'd4, 3'sd2, 8'd255, 1'b1);
   endtask

   // A cleared single reading makes the mean exact, walking the mean through every prefix it can take, -3 to 2.
   task automatic test_mean_prefix_range();
      int p;
      for (p = -3; p <= 3; p++) begin
         send_reading(18'sd1, 3'd0, PREFIX_WIDTH'(p), 8'd85, 1'b1);
      end
      send_reading(18'sd3, 3'd0, -3'sd3, 8'd85, 1'b1);
      send_reading(-18'sd99999, 3'd0, 3'sd2, 8'd85, 1'b1);
   endtask

   // A session of readings of one unit, values clustered around a base so that
   // min, max and the mean all keep moving.
   task automatic send_session(input int length, input logic [UNIT_WIDTH-1:0] unit,
                               input bit clear_first);
      int base_value;
      int value;
      int base_places;
      int base_prefix;
      int places;
      int prefix;
      int spread;
      int i;
      base_value  = int'($urandom_range(0, 199998)) - 99999;
      base_places = $urandom_range(0, 7);
      base_prefix = int'($urandom_range(0, 6)) - 3;
      spread      = $urandom_range(1, 20000);
      for (i = 0; i < length; i++) begin
         value = base_value + int'($urandom_range(0, 2 * spread)) - spread;
         if (value > 99999) value = 99999;
         if (value < -99999) value = -99999;
         if ($urandom_range(0, 99) < 10) value = int'($urandom_range(0, 199998)) - 99999;
         places = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 7) : base_places;
         prefix = ($urandom_range(0, 99) < 10) ? int'($urandom_range(0, 6)) - 3 : base_prefix;
         send_reading(VALUE_WIDTH'(value), PLACES_WIDTH'(places), PREFIX_WIDTH'(prefix),
                      unit, (i == 0) && clear_first);
      end
   endtask

   task automatic test_back_to_back();
      allow_gaps = 1'b0;
      send_session(90, 8'd17, 1'b1);
      send_session(60, 8'd18, 1'b0);
      allow_gaps = 1'b1;
   endtask

   // Mostly well-formed sessions, with bursts of arbitrary bit patterns in between.
   task automatic test_random_sessions();
      int target;
      int burst;
      int i;
      logic [UNIT_WIDTH-1:0] unit;
      target = items_sent + RANDOM_ITEMS;
      unit   = prev_unit;
      while (items_sent < target) begin
         if ($urandom_range(0, 99) < 15) begin
            burst = $urandom_range(1, 4);
            for (i = 0; i < burst; i++) begin
               send_reading(VALUE_WIDTH'($urandom), PLACES_WIDTH'($urandom),
                            PREFIX_WIDTH'($urandom), UNIT_WIDTH'($urandom),
                            1'($urandom_range(0, 1)));
            end
         end else begin
            if ($urandom_range(0, 99) < 40) begin
               unit = UNIT_WIDTH'($urandom);
            end
            send_session($urandom_range(2, 60), unit, $urandom_range(0, 99) < 30);
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      rsp_tready    = 1'b0;
      allow_gaps    = 1'b1;
      fault_count   = 0;
      items_sent    = 0;
      least_counts  = '0;
      least_places  = '0;
      least_prefix  = '0;
      most_counts   = '0;
      most_places   = '0;
      most_prefix   = '0;
      running_mean  = '0;
      reading_count = '0;
      prev_unit     = '0;
      fresh_start   = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_restart_after_reset();
      test_saturation_and_ties();
      test_truncation_toward_zero();
      test_clear_and_unit_change();
      test_mean_prefix_range();
      test_back_to_back();
      test_random_sessions();

      while (pending_summaries.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_summaries.size() != 0) begin
         $display("%0t ns: %0d summary items never arrived", $time, pending_summaries.size());
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/smmmt_pkg.sv
hdl/smmmt_scaler.sv
hdl/smmmt_divider.sv
hdl/scaled_min_max_mean_tracker_core.sv
tb/scaled_min_max_mean_tracker_core_tb.sv
